@@ design/i2cseq_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cseq_pkg
// shared types, codes and defaults of the i2c master transaction sequencer
// ----------------------------------------------------------------------------
package i2cseq_pkg;

	// default depths
	localparam int unsigned SEND_DEPTH_DEF    = 2;
	localparam int unsigned RECEIVE_DEPTH_DEF = 16;

	// configuration port
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_BYTE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_READ_MODE        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TRANSFER_LENGTH  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SEND_BYTE_FIRST  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SEND_BYTE_SECOND = 3'd4;

	// item opcodes
	localparam logic OP_BEGIN  = 1'b0;
	localparam logic OP_STATUS = 1'b1;

	// bus engine status codes, low three bits masked off
	localparam logic [7:0] STATUS_MASK      = 8'hF8;
	localparam logic [7:0] ST_START         = 8'h08;
	localparam logic [7:0] ST_REP_START     = 8'h10;
	localparam logic [7:0] ST_MT_ADDR_ACK   = 8'h18;
	localparam logic [7:0] ST_MT_DATA_ACK   = 8'h28;
	localparam logic [7:0] ST_MR_ADDR_ACK   = 8'h40;
	localparam logic [7:0] ST_MR_DATA_ACK   = 8'h50;
	localparam logic [7:0] ST_MR_DATA_NACK  = 8'h58;

	// largest receive position
	localparam logic [4:0] RX_POS_MAX = 5'd31;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_ACK   = 3'd2,
		CMD_NACK  = 3'd3,
		CMD_STOP  = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [7:0] address_byte;
		logic       read_mode;
		logic [4:0] transfer_length;
		logic [7:0] send_byte_first;
		logic [7:0] send_byte_second;
	} cfg_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] bus_status;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [2:0] bus_command;
		logic       tx_load;
		logic [7:0] tx_byte;
		logic       rx_valid;
		logic [3:0] rx_index;
		logic [7:0] rx_data;
		logic       busy_res;
		logic       error_valid;
		logic [7:0] error_status;
	} result_t;

endpackage

@@ design/i2cseq_if.sv @@
// ----------------------------------------------------------------------------
// i2cseq channel interfaces
// valid/ready channels for items, results and configuration writes
// ----------------------------------------------------------------------------
interface i2cseq_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] bus_status;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output bus_status, output rx_byte,
		input ready);
	modport sink (input valid, input opcode, input bus_status, input rx_byte,
		output ready);
endinterface

interface i2cseq_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] bus_command;
	logic       tx_load;
	logic [7:0] tx_byte;
	logic       rx_valid;
	logic [3:0] rx_index;
	logic [7:0] rx_data;
	logic       busy_res;
	logic       error_valid;
	logic [7:0] error_status;

	modport source (output valid, output bus_command, output tx_load, output tx_byte,
		output rx_valid, output rx_index, output rx_data, output busy_res,
		output error_valid, output error_status, input ready);
	modport sink (input valid, input bus_command, input tx_load, input tx_byte,
		input rx_valid, input rx_index, input rx_data, input busy_res,
		input error_valid, input error_status, output ready);
endinterface

interface i2cseq_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [i2cseq_pkg::CFG_INDEX_W-1:0] index;
	logic [i2cseq_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/i2cseq_step.sv @@
// ----------------------------------------------------------------------------
// i2cseq_step
// next command, result item and next state for one item
// ----------------------------------------------------------------------------
module i2cseq_step #(
	parameter int unsigned SEND_DEPTH    = i2cseq_pkg::SEND_DEPTH_DEF,
	parameter int unsigned RECEIVE_DEPTH = i2cseq_pkg::RECEIVE_DEPTH_DEF,
	parameter int unsigned SPOS_W        = $clog2(SEND_DEPTH + 1)
) (
	input  i2cseq_pkg::cfg_t    cfg,
	input  i2cseq_pkg::item_t   item,
	input  logic                busy,
	input  logic [SPOS_W-1:0]   send_pos,
	input  logic [4:0]          recv_pos,
	output i2cseq_pkg::result_t res,
	output logic                busy_nxt,
	output logic [SPOS_W-1:0]   send_pos_nxt,
	output logic [4:0]          recv_pos_nxt
);

	localparam logic [4:0] SEND_LIM = 5'(SEND_DEPTH);
	localparam logic [8:0] RECV_LIM = 9'(RECEIVE_DEPTH);

	logic [7:0] code;
	logic [4:0] send_cnt;
	logic [7:0] send_val;
	logic [4:0] recv_inc;
	logic       recv_room;
	logic       seen;

	assign code     = item.bus_status & i2cseq_pkg::STATUS_MASK;
	assign send_cnt = (cfg.transfer_length > SEND_LIM) ? SEND_LIM : cfg.transfer_length;
	assign recv_inc = (recv_pos < i2cseq_pkg::RX_POS_MAX) ? recv_pos + 5'd1 : recv_pos;
	assign recv_room = ({4'd0, recv_pos} < RECV_LIM);

	always_comb begin
		case (5'(send_pos))
			5'd0:    send_val = cfg.send_byte_first;
			5'd1:    send_val = cfg.send_byte_second;
			default: send_val = 8'd0;
		endcase
	end

	always_comb begin
		res          = '0;
		busy_nxt     = busy;
		send_pos_nxt = send_pos;
		recv_pos_nxt = recv_pos;
		seen         = 1'b0;
		if (item.opcode == i2cseq_pkg::OP_BEGIN) begin
			seen = 1'b1;
			if (!busy) begin
				busy_nxt        = 1'b1;
				send_pos_nxt    = '0;
				recv_pos_nxt    = '0;
				res.bus_command = i2cseq_pkg::CMD_START;
			end
		end else if (busy) begin
			seen = 1'b1;
			case (code)
				i2cseq_pkg::ST_START, i2cseq_pkg::ST_REP_START: begin
					res.tx_load     = 1'b1;
					res.tx_byte     = {cfg.address_byte[7:1],
						cfg.address_byte[0] | cfg.read_mode};
					res.bus_command = i2cseq_pkg::CMD_ACK;
				end
				i2cseq_pkg::ST_MT_ADDR_ACK, i2cseq_pkg::ST_MT_DATA_ACK: begin
					if (5'(send_pos) != send_cnt) begin
						res.tx_load     = 1'b1;
						res.tx_byte     = send_val;
						send_pos_nxt    = SPOS_W'(send_pos + 1'b1);
						res.bus_command = i2cseq_pkg::CMD_ACK;
					end else begin
						res.bus_command = i2cseq_pkg::CMD_STOP;
						busy_nxt        = 1'b0;
					end
				end
				i2cseq_pkg::ST_MR_DATA_NACK: begin
					if (recv_room) begin
						res.rx_valid = 1'b1;
						res.rx_index = recv_pos[3:0];
						res.rx_data  = item.rx_byte;
					end
					res.bus_command = i2cseq_pkg::CMD_STOP;
					busy_nxt        = 1'b0;
				end
				i2cseq_pkg::ST_MR_DATA_ACK: begin
					if (recv_room) begin
						res.rx_valid = 1'b1;
						res.rx_index = recv_pos[3:0];
						res.rx_data  = item.rx_byte;
					end
					recv_pos_nxt    = recv_inc;
					res.bus_command = ({1'b0, recv_inc} + 6'd1 < {1'b0, cfg.transfer_length})
						? i2cseq_pkg::CMD_ACK : i2cseq_pkg::CMD_NACK;
				end
				i2cseq_pkg::ST_MR_ADDR_ACK: begin
					res.bus_command = ({1'b0, recv_pos} + 6'd1 < {1'b0, cfg.transfer_length})
						? i2cseq_pkg::CMD_ACK : i2cseq_pkg::CMD_NACK;
				end
				default: begin
					res.error_valid  = 1'b1;
					res.error_status = code;
					res.bus_command  = i2cseq_pkg::CMD_STOP;
					busy_nxt         = 1'b0;
				end
			endcase
		end
		res.busy_res = seen & busy_nxt;
	end

endmodule

@@ design/i2c_master_transaction_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_unit
// status driven sequencer for one i2c master read or write transaction
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries items: a begin item (opcode 0) or a bus engine status event
//   (opcode 1) with the raw status byte and the received data byte.
//   out_ch returns exactly one result per item: the next bus command, a byte
//   to load into the engine data register, a delivered receive byte with its
//   index, the busy flag and an error report.
//   cfg_ch writes the five registers (address byte, read mode, transfer
//   length, two send bytes); it is always ready and should be written only
//   while no transaction is in flight. Unknown indexes are dropped.
// timing:
//   an item is held in the input register, its result is computed by the
//   step logic and lands in the output register; while out_ch.ready is high
//   a new item can be taken every cycle (1 item per cycle sustained).
// reset:
//   arst_n clears registers, the busy flag and both positions; no item is held.
// stall:
//   while out_ch.ready is low the result register holds, the input register
//   keeps its item and in_ch.ready drops once both are full.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_unit #(
	parameter int unsigned SEND_DEPTH    = i2cseq_pkg::SEND_DEPTH_DEF,
	parameter int unsigned RECEIVE_DEPTH = i2cseq_pkg::RECEIVE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	i2cseq_in_if.sink    in_ch,
	i2cseq_out_if.source out_ch,
	i2cseq_cfg_if.sink   cfg_ch
);

	localparam int unsigned SPOS_W = $clog2(SEND_DEPTH + 1);

	// configuration registers
	i2cseq_pkg::cfg_t cfg_q;

	// input register stage
	i2cseq_pkg::item_t item_s1;
	logic              valid_s1;

	// transaction state
	logic              busy_q;
	logic [SPOS_W-1:0] send_pos_q;
	logic [4:0]        recv_pos_q;

	// result register
	i2cseq_pkg::result_t res_q;
	logic                out_valid_q;

	// step outputs
	i2cseq_pkg::result_t res_d;
	logic                busy_d;
	logic [SPOS_W-1:0]   send_pos_d;
	logic [4:0]          recv_pos_d;

	logic in_take;
	logic adv_s1;

	// the staged item moves on when the result register is empty or drains now
	assign adv_s1       = valid_s1 & (~out_valid_q | out_ch.ready);
	assign in_ch.ready  = ~valid_s1 | adv_s1;
	assign in_take      = in_ch.valid & in_ch.ready;
	assign cfg_ch.ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				i2cseq_pkg::REG_ADDRESS_BYTE:     cfg_q.address_byte     <= cfg_ch.data;
				i2cseq_pkg::REG_READ_MODE:        cfg_q.read_mode        <= cfg_ch.data[0];
				i2cseq_pkg::REG_TRANSFER_LENGTH:  cfg_q.transfer_length  <= cfg_ch.data[4:0];
				i2cseq_pkg::REG_SEND_BYTE_FIRST:  cfg_q.send_byte_first  <= cfg_ch.data;
				i2cseq_pkg::REG_SEND_BYTE_SECOND: cfg_q.send_byte_second <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	// input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= '{opcode: in_ch.opcode, bus_status: in_ch.bus_status,
				rx_byte: in_ch.rx_byte};
		end
	end

	// per item decision logic
	i2cseq_step #(
		.SEND_DEPTH    (SEND_DEPTH),
		.RECEIVE_DEPTH (RECEIVE_DEPTH),
		.SPOS_W        (SPOS_W)
	) u_step (
		.cfg          (cfg_q),
		.item         (item_s1),
		.busy         (busy_q),
		.send_pos     (send_pos_q),
		.recv_pos     (recv_pos_q),
		.res          (res_d),
		.busy_nxt     (busy_d),
		.send_pos_nxt (send_pos_d),
		.recv_pos_nxt (recv_pos_d)
	);

	// state commits when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			send_pos_q <= '0;
			recv_pos_q <= '0;
		end else if (adv_s1) begin
			busy_q     <= busy_d;
			send_pos_q <= send_pos_d;
			recv_pos_q <= recv_pos_d;
		end
	end

	// result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.bus_command  = res_q.bus_command;
	assign out_ch.tx_load      = res_q.tx_load;
	assign out_ch.tx_byte      = res_q.tx_byte;
	assign out_ch.rx_valid     = res_q.rx_valid;
	assign out_ch.rx_index     = res_q.rx_index;
	assign out_ch.rx_data      = res_q.rx_data;
	assign out_ch.busy_res     = res_q.busy_res;
	assign out_ch.error_valid  = res_q.error_valid;
	assign out_ch.error_status = res_q.error_status;

endmodule

@@ design/i2cseq_checker.sv @@
// ----------------------------------------------------------------------------
// i2cseq_checker
// port level checks of the sequencer results, bound to the top level
// ----------------------------------------------------------------------------
module i2cseq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] bus_command,
	input logic       tx_load,
	input logic       rx_valid,
	input logic       busy_res,
	input logic       error_valid
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// an error always closes the transaction with a stop
	a_err_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_valid |->
			bus_command == i2cseq_pkg::CMD_STOP && !busy_res && !tx_load && !rx_valid)
		else $error("error without stop");

	// a byte to load always goes with a continue and ack
	a_load_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_load |-> bus_command == i2cseq_pkg::CMD_ACK && busy_res)
		else $error("tx load without ack");

	// a delivered byte comes with ack, nack or stop
	a_rx_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_valid |->
			bus_command == i2cseq_pkg::CMD_ACK || bus_command == i2cseq_pkg::CMD_NACK ||
			bus_command == i2cseq_pkg::CMD_STOP)
		else $error("rx byte with wrong command");

endmodule

bind i2c_master_transaction_sequencer_unit i2cseq_checker u_i2cseq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.bus_command (out_ch.bus_command),
	.tx_load     (out_ch.tx_load),
	.rx_valid    (out_ch.rx_valid),
	.busy_res    (out_ch.busy_res),
	.error_valid (out_ch.error_valid)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the i2c master transaction sequencer: a clocked
// driver feeds begin and bus status items from a queue, a shadow model of the
// sequencer predicts one result per accepted item, and a clocked monitor
// compares every returned result field by field, under random back-pressure
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 6;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 4;
	localparam int LONG_HOLD       = 200;
	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 70;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	i2cseq_in_if  in_ch ();
	i2cseq_out_if out_ch ();
	i2cseq_cfg_if cfg_ch ();

	i2c_master_transaction_sequencer_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	always #CLK_HALF clk = ~clk;

	// items waiting to be offered and results still owed by the block
	i2cseq_pkg::item_t   pending_items[$];
	i2cseq_pkg::result_t expected_results[$];
	i2cseq_pkg::item_t   offered;

	// shadow of the register file and of the sequencer state
	i2cseq_pkg::cfg_t live_cfg   = '0;
	logic             txn_busy   = 1'b0;
	int unsigned      send_pos   = 0;
	int unsigned      recv_pos   = 0;
	logic [7:0]       last_error = 8'h00;

	// idle percentages, long hold-off handshake and bookkeeping
	int unsigned send_idle_pct   = 0;
	int unsigned recv_idle_pct   = 0;
	logic        long_hold_armed = 1'b0;
	logic        long_hold_done  = 1'b0;
	int unsigned hold_left       = 0;
	int unsigned mismatches      = 0;
	int unsigned items_queued    = 0;
	int unsigned idle_cycles     = 0;

	// reply to the next received byte: nack once the transfer is about to end
	function automatic i2cseq_pkg::cmd_t rx_reply();
		return (recv_pos + 1 < live_cfg.transfer_length) ?
			i2cseq_pkg::CMD_ACK : i2cseq_pkg::CMD_NACK;
	endfunction

	// advance the shadow sequencer by one item and return the result it owes
	function automatic i2cseq_pkg::result_t next_bus_action(i2cseq_pkg::item_t it);
		i2cseq_pkg::result_t r;
		logic [7:0]          code;
		int unsigned         send_total;
		r = '0;
		code = it.bus_status & i2cseq_pkg::STATUS_MASK;
		// writes never send more than the send registers hold
		send_total = (live_cfg.transfer_length > i2cseq_pkg::SEND_DEPTH_DEF) ?
			i2cseq_pkg::SEND_DEPTH_DEF : live_cfg.transfer_length;
		if (it.opcode == i2cseq_pkg::OP_BEGIN) begin
			// a begin while busy is swallowed, only busy is reported
			if (!txn_busy) begin
				txn_busy = 1'b1;
				last_error = 8'h00;
				send_pos = 0;
				recv_pos = 0;
				r.bus_command = i2cseq_pkg::CMD_START;
			end
			r.busy_res = txn_busy;
		end else if (txn_busy) begin
			case (code)
				i2cseq_pkg::ST_START, i2cseq_pkg::ST_REP_START: begin
					// address byte, read flag forced into bit zero
					r.tx_load = 1'b1;
					r.tx_byte = live_cfg.address_byte | {7'd0, live_cfg.read_mode};
					r.bus_command = i2cseq_pkg::CMD_ACK;
				end
				i2cseq_pkg::ST_MT_ADDR_ACK, i2cseq_pkg::ST_MT_DATA_ACK: begin
					if (send_pos != send_total) begin
						r.tx_load = 1'b1;
						r.tx_byte = (send_pos == 0) ? live_cfg.send_byte_first :
							(send_pos == 1) ? live_cfg.send_byte_second : 8'h00;
						send_pos++;
						r.bus_command = i2cseq_pkg::CMD_ACK;
					end else begin
						r.bus_command = i2cseq_pkg::CMD_STOP;
						txn_busy = 1'b0;
					end
				end
				i2cseq_pkg::ST_MR_DATA_NACK: begin
					// last byte of a read, still delivered if it fits the depth
					if (recv_pos < i2cseq_pkg::RECEIVE_DEPTH_DEF) begin
						r.rx_valid = 1'b1;
						r.rx_index = 4'(recv_pos);
						r.rx_data = it.rx_byte;
					end
					r.bus_command = i2cseq_pkg::CMD_STOP;
					txn_busy = 1'b0;
				end
				i2cseq_pkg::ST_MR_DATA_ACK: begin
					if (recv_pos < i2cseq_pkg::RECEIVE_DEPTH_DEF) begin
						r.rx_valid = 1'b1;
						r.rx_index = 4'(recv_pos);
						r.rx_data = it.rx_byte;
					end
					// position saturates instead of wrapping
					if (recv_pos < i2cseq_pkg::RX_POS_MAX) recv_pos++;
					r.bus_command = rx_reply();
				end
				i2cseq_pkg::ST_MR_ADDR_ACK: begin
					r.bus_command = rx_reply();
				end
				default: begin
					// unknown status aborts the transaction with a stop
					r.error_valid = 1'b1;
					r.error_status = code;
					last_error = code;
					r.bus_command = i2cseq_pkg::CMD_STOP;
					txn_busy = 1'b0;
				end
			endcase
			r.busy_res = txn_busy;
		end
		// status while idle falls through with an all-zero result
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t mismatch %s: expected 0x%0h, actual 0x%0h", $realtime, name,
				want, got);
			mismatches++;
		end
	endtask

	// driver: offer queued items, predict each one at the edge that takes it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_results.push_back(next_bus_action(offered));
			end
			// a new item only when the bus is free or the current one was taken
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = pending_items.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.opcode <= offered.opcode;
					in_ch.bus_status <= offered.bus_status;
					in_ch.rx_byte <= offered.rx_byte;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each returned result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		i2cseq_pkg::result_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result: expected none, actual cmd 0x%0h",
						$realtime, out_ch.bus_command);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("bus_command", want.bus_command, out_ch.bus_command);
					check_field("tx_load", want.tx_load, out_ch.tx_load);
					check_field("tx_byte", want.tx_byte, out_ch.tx_byte);
					check_field("rx_valid", want.rx_valid, out_ch.rx_valid);
					check_field("rx_index", want.rx_index, out_ch.rx_index);
					check_field("rx_data", want.rx_data, out_ch.rx_data);
					check_field("busy_res", want.busy_res, out_ch.busy_res);
					check_field("error_valid", want.error_valid, out_ch.error_valid);
					check_field("error_status", want.error_status, out_ch.error_status);
				end
			end
			// one long hold-off so the block fills up and stalls its input
			if (long_hold_armed && !long_hold_done) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog: too many cycles without any handshake ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no handshake for %0d cycles", $realtime, idle_cycles);
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	task automatic push_item(input logic op, input logic [7:0] status,
		input logic [7:0] rx);
		i2cseq_pkg::item_t it;
		it = '{opcode: op, bus_status: status, rx_byte: rx};
		pending_items.push_back(it);
		items_queued++;
	endtask

	// write all five registers back to back, valid stays high between them
	task automatic write_config(input i2cseq_pkg::cfg_t c);
		logic [i2cseq_pkg::CFG_INDEX_W-1:0] idx[5];
		logic [i2cseq_pkg::CFG_DATA_W-1:0]  val[5];
		idx = '{i2cseq_pkg::REG_ADDRESS_BYTE, i2cseq_pkg::REG_READ_MODE,
			i2cseq_pkg::REG_TRANSFER_LENGTH, i2cseq_pkg::REG_SEND_BYTE_FIRST,
			i2cseq_pkg::REG_SEND_BYTE_SECOND};
		val = '{c.address_byte, {7'd0, c.read_mode}, {3'd0, c.transfer_length},
			c.send_byte_first, c.send_byte_second};
		for (int i = 0; i < 5; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data <= val[i];
			do @(posedge clk); while (!cfg_ch.ready);
			case (idx[i])
				i2cseq_pkg::REG_ADDRESS_BYTE:     live_cfg.address_byte = val[i];
				i2cseq_pkg::REG_READ_MODE:        live_cfg.read_mode = val[i][0];
				i2cseq_pkg::REG_TRANSFER_LENGTH:  live_cfg.transfer_length = val[i][4:0];
				i2cseq_pkg::REG_SEND_BYTE_FIRST:  live_cfg.send_byte_first = val[i];
				i2cseq_pkg::REG_SEND_BYTE_SECOND: live_cfg.send_byte_second = val[i];
				default: ;
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// wait until every item is taken and every result is back, then settle
	task automatic drain();
		while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		@(posedge clk);
	endtask

	// drain, and abort a transaction left open so the next setting starts idle
	task automatic end_phase();
		drain();
		if (txn_busy) begin
			push_item(i2cseq_pkg::OP_STATUS, 8'h00, 8'h00);
			drain();
		end
	endtask

	// one well-formed transaction for the current setting, sometimes broken
	task automatic add_transaction();
		i2cseq_pkg::item_t seq[$];
		int unsigned       ndata;
		int unsigned       pos;
		seq.push_back('{opcode: i2cseq_pkg::OP_BEGIN, bus_status: 8'($urandom),
			rx_byte: 8'($urandom)});
		seq.push_back('{opcode: i2cseq_pkg::OP_STATUS,
			bus_status: ($urandom_range(1) ? i2cseq_pkg::ST_START : i2cseq_pkg::ST_REP_START)
				| 8'($urandom_range(7)),
			rx_byte: 8'($urandom)});
		if (live_cfg.read_mode) begin
			seq.push_back('{opcode: i2cseq_pkg::OP_STATUS,
				bus_status: i2cseq_pkg::ST_MR_ADDR_ACK | 8'($urandom_range(7)),
				rx_byte: 8'($urandom)});
			// occasionally a read far past the receive depth
			ndata = ($urandom_range(19) == 0) ? $urandom_range(40, 34) :
				((live_cfg.transfer_length == 0) ? 0 : live_cfg.transfer_length - 1);
			for (int i = 0; i < ndata; i++)
				seq.push_back('{opcode: i2cseq_pkg::OP_STATUS,
					bus_status: i2cseq_pkg::ST_MR_DATA_ACK | 8'($urandom_range(7)),
					rx_byte: 8'($urandom)});
			seq.push_back('{opcode: i2cseq_pkg::OP_STATUS,
				bus_status: i2cseq_pkg::ST_MR_DATA_NACK | 8'($urandom_range(7)),
				rx_byte: 8'($urandom)});
		end else begin
			seq.push_back('{opcode: i2cseq_pkg::OP_STATUS,
				bus_status: i2cseq_pkg::ST_MT_ADDR_ACK | 8'($urandom_range(7)),
				rx_byte: 8'($urandom)});
			ndata = (live_cfg.transfer_length > i2cseq_pkg::SEND_DEPTH_DEF) ?
				i2cseq_pkg::SEND_DEPTH_DEF : live_cfg.transfer_length;
			// now and then extra acks land after the stop
			if ($urandom_range(9) == 0) ndata += $urandom_range(2, 1);
			for (int i = 0; i < ndata; i++)
				seq.push_back('{opcode: i2cseq_pkg::OP_STATUS,
					bus_status: i2cseq_pkg::ST_MT_DATA_ACK | 8'($urandom_range(7)),
					rx_byte: 8'($urandom)});
		end
		// broken sequences: a random status in place of one event, or a cut tail
		if ($urandom_range(99) < 12) begin
			pos = $urandom_range(seq.size() - 1, 1);
			seq[pos].bus_status = 8'($urandom);
		end
		if ($urandom_range(99) < 5) void'(seq.pop_back());
		foreach (seq[i]) push_item(seq[i].opcode, seq[i].bus_status, seq[i].rx_byte);
	endtask

	initial begin
		i2cseq_pkg::cfg_t c;
		int unsigned      phase_start;
		int unsigned      sel;
		// known values on every block input from time zero
		in_ch.valid = 1'b0;
		in_ch.opcode = i2cseq_pkg::OP_BEGIN;
		in_ch.bus_status = 8'h00;
		in_ch.rx_byte = 8'h00;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = i2cseq_pkg::REG_ADDRESS_BYTE;
		cfg_ch.data = 8'h00;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 18;
		recv_idle_pct = 52;

		// directed write: idle status, begin while busy, two sends and a stop,
		// repeated start, unknown status codes
		c = '{address_byte: 8'hA4, read_mode: 1'b0, transfer_length: 5'd2,
			send_byte_first: 8'h00, send_byte_second: 8'hFF};
		write_config(c);
		push_item(i2cseq_pkg::OP_STATUS, 8'hFF, 8'hFF);
		push_item(i2cseq_pkg::OP_BEGIN, 8'h00, 8'h00);
		push_item(i2cseq_pkg::OP_BEGIN, 8'hFF, 8'hFF);
		push_item(i2cseq_pkg::OP_STATUS, i2cseq_pkg::ST_START | 8'h07, 8'h00);
		push_item(i2cseq_pkg::OP_STATUS, i2cseq_pkg::ST_MT_ADDR_ACK, 8'h00);
		push_item(i2cseq_pkg::OP_STATUS, i2cseq_pkg::ST_MT_DATA_ACK | 8'h03, 8'h00);
		push_item(i2cseq_pkg::OP_STATUS, i2cseq_pkg::ST_MT_DATA_ACK, 8'h00);
		push_item(i2cseq_pkg::OP_BEGIN, 8'h00, 8'h00);
		push_item(i2cseq_pkg::OP_STATUS, i2cseq_pkg::ST_REP_START, 8'h00);
		push_item(i2cseq_pkg::OP_STATUS, 8'h3D, 8'h00);
		push_item(i2cseq_pkg::OP_BEGIN, 8'h00, 8'h00);
		push_item(i2cseq_pkg::OP_STATUS, 8'h00, 8'hFF);
		end_phase();

		// directed read: address bit zero forced, ack then nack at the end,
		// transmit codes inside a read, all-ones status
		c = '{address_byte: 8'h00, read_mode: 1'b1, transfer_length: 5'd3,
			send_byte_first: 8'h5A, send_byte_second: 8'hA5};
		write_config(c);
		push_item(i2cseq_pkg::OP_BEGIN, 8'h00, 8'h00);
		push_item(i2cseq_pkg::OP_STATUS, i2cseq_pkg::ST_START, 8'h00);
		push_item(i2cseq_pkg::OP_STATUS, i2cseq_pkg::ST_MR_ADDR_ACK | 8'h07, 8'h00);
		push_item(i2cseq_pkg::OP_STATUS, i2cseq_pkg::ST_MR_DATA_ACK, 8'h00);
		push_item(i2cseq_pkg::OP_STATUS, i2cseq_pkg::ST_MR_DATA_ACK | 8'h05, 8'hFF);
		push_item(i2cseq_pkg::OP_STATUS, i2cseq_pkg::ST_MR_DATA_NACK, 8'h81);
		push_item(i2cseq_pkg::OP_BEGIN, 8'h00, 8'h00);
		push_item(i2cseq_pkg::OP_STATUS, i2cseq_pkg::ST_MT_ADDR_ACK, 8'h00);
		push_item(i2cseq_pkg::OP_STATUS, i2cseq_pkg::ST_MR_DATA_NACK | 8'h07, 8'h7E);
		push_item(i2cseq_pkg::OP_BEGIN, 8'h00, 8'h00);
		push_item(i2cseq_pkg::OP_STATUS, 8'hFF, 8'h00);
		end_phase();

		// random phases, each under a fresh register setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			// sender idles lightly first, then the receiver, then nobody
			if (p < RANDOM_PHASES / 3) begin
				send_idle_pct = 18;
				recv_idle_pct = 52;
			end else if (p < 2 * RANDOM_PHASES / 3) begin
				send_idle_pct = 52;
				recv_idle_pct = 18;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			c = '{address_byte: 8'($urandom), read_mode: (p % 3 == 0),
				transfer_length: 5'($urandom_range(16)),
				send_byte_first: 8'($urandom), send_byte_second: 8'($urandom)};
			// extremes of the setting every few phases
			case (p % 4)
				0: begin
					c.transfer_length = 5'd16;
					c.address_byte = 8'hFF;
					c.send_byte_first = 8'hFF;
					c.send_byte_second = 8'hFF;
				end
				1: begin
					c.transfer_length = 5'd0;
					c.address_byte = 8'h00;
					c.send_byte_first = 8'h00;
					c.send_byte_second = 8'h00;
				end
				2: c.transfer_length = 5'd1;
				default: ;
			endcase
			write_config(c);
			if (p == 2 * RANDOM_PHASES / 3) long_hold_armed = 1'b1;
			phase_start = items_queued;
			while (items_queued - phase_start < ITEMS_PER_PHASE) begin
				sel = $urandom_range(99);
				if (sel < 78) begin
					add_transaction();
				end else if (sel < 92) begin
					push_item(1'($urandom), 8'($urandom), 8'($urandom));
				end else begin
					push_item(i2cseq_pkg::OP_BEGIN, 8'($urandom), 8'($urandom));
				end
			end
			end_phase();
		end

		if (mismatches == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
